// ===== rtl/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator package
// Widths, register and status codes, and the command/status bundles shared
// by the controller and the datapath.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int UnitsLog2 = 10;
  localparam int NodeW     = UnitsLog2 + 1;
  localparam int WordLog2  = (UnitsLog2 >= 5) ? 5 : UnitsLog2;
  localparam int WordBits  = 1 << WordLog2;
  localparam int WordIdxW  = NodeW - WordLog2;
  localparam int NumWords  = 1 << WordIdxW;
  localparam int NumUnits  = 1 << UnitsLog2;
  localparam int LvlW      = $clog2(UnitsLog2 + 1);
  localparam int EffLvlW   = $clog2(UnitsLog2 + 2);
  localparam int LvlCmpW   = EffLvlW + 1;

  localparam int AddrW    = 26;
  localparam int LenW     = 26;
  localparam int NeedW    = 28;
  localparam int PoolW    = 27;
  localparam int BlogW    = 5;
  localparam int LevelsW  = 4;
  localparam int HdrW     = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;
  localparam int StatW    = 2;

  localparam logic [CfgIdxW-1:0] CfgBlockLog2 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLevels    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeader    = 2'd2;

  localparam logic [StatW-1:0] StOk      = 2'd0;
  localparam logic [StatW-1:0] StNoMem   = 2'd1;
  localparam logic [StatW-1:0] StBadLen  = 2'd2;
  localparam logic [StatW-1:0] StBadAddr = 2'd3;

  localparam logic CmdFree = 1'b1;

  typedef struct packed {
    logic             clr_step;
    logic             load;
    logic             pick_level;
    logic             scan_rd;
    logic             scan_next_word;
    logic             scan_next_level;
    logic             take_hit;
    logic             desc;
    logic             desc_keep;
    logic             unit_calc;
    logic             am_rd;
    logic             am_wr;
    logic             am_mark;
    logic             load_free;
    logic             merge_up;
    logic             bf_rd;
    logic             bf_wr;
    logic             sel_buddy;
    logic             wr_val;
    logic             set_stat;
    logic [StatW-1:0] stat_code;
    logic             set_res;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic clr_last;
    logic is_free;
    logic bad_len;
    logic no_fit;
    logic bad_addr;
    logic scan_hit;
    logic more_words;
    logic lvl_below_top;
    logic can_split;
    logic am_mark;
    logic buddy_free;
  } sts_t;

endpackage

// ===== rtl/bma_datapath.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Configuration registers, free-block bitmap memory, allocation record memory
// and the working registers of one transaction.
// ----------------------------------------------------------------------------
module bma_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [bma_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bma_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_command,
  input  logic [bma_pkg::LenW-1:0]      in_length,
  input  logic [bma_pkg::AddrW-1:0]     in_address,
  input  bma_pkg::cmd_t                 cmd,
  output bma_pkg::sts_t                 sts,
  output logic [bma_pkg::StatW-1:0]     stat,
  output logic [bma_pkg::AddrW-1:0]     res
);

  logic [bma_pkg::BlogW-1:0]    cfg_blog;
  logic [bma_pkg::LevelsW-1:0]  cfg_levels;
  logic [bma_pkg::HdrW-1:0]     cfg_hdr;
  logic [bma_pkg::BlogW-1:0]    eff_blog;
  logic [bma_pkg::EffLvlW-1:0]  eff_levels;
  logic [bma_pkg::HdrW-1:0]     eff_hdr;
  logic                         cfg_wr;

  logic [bma_pkg::UnitsLog2-1:0] clr_cnt;
  logic [bma_pkg::NodeW-1:0]     top_node;

  logic                          op_cmd;
  logic [bma_pkg::LenW-1:0]      op_len;
  logic [bma_pkg::AddrW-1:0]     op_addr;
  logic [bma_pkg::NeedW-1:0]     need;
  logic [bma_pkg::LvlW-1:0]      lvl;
  logic [bma_pkg::LvlW-1:0]      cur_lvl;
  logic [bma_pkg::NodeW-1:0]     node;
  logic [bma_pkg::WordIdxW-1:0]  word;
  logic [bma_pkg::UnitsLog2-1:0] unit;

  logic [bma_pkg::WordBits-1:0]  bf_mem [bma_pkg::NumWords];
  logic [bma_pkg::WordBits-1:0]  bf_q;
  logic [bma_pkg::LvlW:0]        am_mem [bma_pkg::NumUnits];
  logic [bma_pkg::LvlW:0]        am_q;

  // check and level pick
  logic [bma_pkg::PoolW-1:0]     pool;
  logic [bma_pkg::UnitsLog2:0]   fits;
  logic [bma_pkg::LvlW-1:0]      fit_lvl;
  logic [bma_pkg::AddrW-1:0]     start;
  logic [bma_pkg::AddrW-1:0]     blk_mask;
  logic [bma_pkg::UnitsLog2-1:0] unit_f;
  logic [bma_pkg::NodeW-1:0]     lo_fit;

  // scan
  logic [bma_pkg::NodeW-1:0]     lo;
  logic [bma_pkg::NodeW-1:0]     lo_last;
  logic [bma_pkg::NodeW-1:0]     lo_next;
  logic [bma_pkg::WordBits-1:0]  cand;
  logic [bma_pkg::WordLog2-1:0]  hit_idx;
  logic [bma_pkg::NodeW-1:0]     hit_node;

  // bitmap access
  logic [bma_pkg::NodeW-1:0]     tgt;
  logic [bma_pkg::WordIdxW-1:0]  bf_ra;
  logic                          bf_we;
  logic [bma_pkg::WordIdxW-1:0]  bf_wa;
  logic [bma_pkg::WordBits-1:0]  bf_wd;
  logic                          am_we;
  logic [bma_pkg::UnitsLog2-1:0] am_wa;
  logic [bma_pkg::LvlW:0]        am_wd;
  logic [bma_pkg::LvlW-1:0]      am_lvl;

  assign cfg_wr = cfg_valid && (cfg_index == bma_pkg::CfgBlockLog2 ||
                                cfg_index == bma_pkg::CfgLevels ||
                                cfg_index == bma_pkg::CfgHeader);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_blog   <= bma_pkg::BlogW'(7);
      cfg_levels <= bma_pkg::LevelsW'(11);
      cfg_hdr    <= bma_pkg::HdrW'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        bma_pkg::CfgBlockLog2: cfg_blog   <= cfg_data[bma_pkg::BlogW-1:0];
        bma_pkg::CfgLevels:    cfg_levels <= cfg_data[bma_pkg::LevelsW-1:0];
        bma_pkg::CfgHeader:    cfg_hdr    <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate the raw registers so the pool always fits 26-bit offsets
  always_comb begin
    int b;
    int l;
    b = int'(cfg_blog);
    if (b < 4) b = 4;
    if (b > 16) b = 16;
    l = int'(cfg_levels);
    if (l < 1) l = 1;
    if (l > bma_pkg::UnitsLog2 + 1) l = bma_pkg::UnitsLog2 + 1;
    if (l > 27 - b) l = 27 - b;
    eff_blog   = bma_pkg::BlogW'(b);
    eff_levels = bma_pkg::EffLvlW'(l);
    eff_hdr    = (cfg_hdr > bma_pkg::HdrW'(32)) ? bma_pkg::HdrW'(32) : cfg_hdr;
  end

  assign top_node = bma_pkg::NodeW'(1) <<
                    (bma_pkg::EffLvlW'(bma_pkg::NodeW) - eff_levels);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // ---------------- checks on the loaded item ----------------
  assign pool = bma_pkg::PoolW'(1) << (6'(eff_blog) + 6'(eff_levels) - 6'd1);

  always_comb begin
    for (int i = 0; i <= bma_pkg::UnitsLog2; i++) begin
      fits[i] = (i < int'(eff_levels)) &&
                (need <= (bma_pkg::NeedW'(1) << (int'(eff_blog) + i)));
    end
    fit_lvl = '0;
    for (int i = bma_pkg::UnitsLog2; i >= 0; i--) begin
      if (fits[i]) fit_lvl = bma_pkg::LvlW'(i);
    end
  end

  assign lo_fit   = bma_pkg::NodeW'(1) << (bma_pkg::LvlW'(bma_pkg::UnitsLog2) - fit_lvl);
  assign start    = op_addr - bma_pkg::AddrW'(eff_hdr);
  assign blk_mask = (bma_pkg::AddrW'(1) << eff_blog) - bma_pkg::AddrW'(1);
  assign unit_f   = bma_pkg::UnitsLog2'(start >> eff_blog);

  // ---------------- scan of one bitmap word ----------------
  assign lo      = bma_pkg::NodeW'(1) << (bma_pkg::LvlW'(bma_pkg::UnitsLog2) - cur_lvl);
  assign lo_last = (lo << 1) - bma_pkg::NodeW'(1);
  assign lo_next = lo >> 1;

  always_comb begin
    logic [bma_pkg::NodeW-1:0] n;
    for (int i = 0; i < bma_pkg::WordBits; i++) begin
      n = {word, bma_pkg::WordLog2'(i)};
      cand[i] = bf_q[i] && (n >= lo) && (n <= lo_last);
    end
    hit_idx = '0;
    for (int i = bma_pkg::WordBits - 1; i >= 0; i--) begin
      if (cand[i]) hit_idx = bma_pkg::WordLog2'(i);
    end
  end

  assign hit_node = {word, hit_idx};

  // ---------------- bitmap memory ----------------
  assign tgt    = cmd.sel_buddy ? (node ^ bma_pkg::NodeW'(1)) : node;
  assign bf_ra  = cmd.scan_rd ? word : tgt[bma_pkg::NodeW-1:bma_pkg::WordLog2];
  assign am_lvl = am_q[bma_pkg::LvlW-1:0];

  always_comb begin
    bf_we = 1'b0;
    bf_wa = tgt[bma_pkg::NodeW-1:bma_pkg::WordLog2];
    bf_wd = bf_q;
    if (cmd.clr_step) begin
      bf_we = {1'b0, clr_cnt} < (bma_pkg::UnitsLog2 + 1)'(bma_pkg::NumWords);
      bf_wa = clr_cnt[bma_pkg::WordIdxW-1:0];
      bf_wd = '0;
      if (clr_cnt[bma_pkg::WordIdxW-1:0] == top_node[bma_pkg::NodeW-1:bma_pkg::WordLog2])
        bf_wd[top_node[bma_pkg::WordLog2-1:0]] = 1'b1;
    end else if (cmd.bf_wr) begin
      bf_we = 1'b1;
      bf_wd[tgt[bma_pkg::WordLog2-1:0]] = cmd.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (bf_we) bf_mem[bf_wa] <= bf_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.bf_rd) bf_q <= bf_mem[bf_ra];
  end

  // ---------------- allocation record memory ----------------
  always_comb begin
    am_we = cmd.clr_step || cmd.am_wr;
    am_wa = cmd.clr_step ? clr_cnt : unit;
    am_wd = cmd.clr_step ? '0 : {cmd.am_mark, cmd.am_mark ? lvl : am_lvl};
  end

  always_ff @(posedge clk) begin
    if (am_we) am_mem[am_wa] <= am_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.am_rd) am_q <= am_mem[unit];
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_cmd  <= in_command;
      op_len  <= in_length;
      op_addr <= in_address;
      need    <= bma_pkg::NeedW'(in_length) + bma_pkg::NeedW'(eff_hdr);
    end
    if (cmd.pick_level) begin
      lvl     <= fit_lvl;
      cur_lvl <= fit_lvl;
      word    <= lo_fit[bma_pkg::NodeW-1:bma_pkg::WordLog2];
    end
    if (cmd.scan_next_word) word <= word + 1'b1;
    if (cmd.scan_next_level) begin
      cur_lvl <= cur_lvl + 1'b1;
      word    <= lo_next[bma_pkg::NodeW-1:bma_pkg::WordLog2];
    end
    if (cmd.take_hit) begin
      node <= hit_node;
      unit <= bma_pkg::UnitsLog2'((hit_node & (lo - bma_pkg::NodeW'(1))) << cur_lvl);
    end
    // step to the right child of the found node, or of the left buddy of the current right half
    if (cmd.desc) begin
      node    <= {node[bma_pkg::NodeW-2:1], cmd.desc_keep ? node[0] : 1'b0, 1'b1};
      cur_lvl <= cur_lvl - 1'b1;
    end
    if (cmd.unit_calc) unit <= unit_f;
    if (cmd.load_free) begin
      cur_lvl <= am_lvl;
      node    <= (bma_pkg::NodeW'(1) << (bma_pkg::LvlW'(bma_pkg::UnitsLog2) - am_lvl)) +
                 bma_pkg::NodeW'(unit >> am_lvl);
    end
    if (cmd.merge_up) begin
      node    <= node >> 1;
      cur_lvl <= cur_lvl + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stat <= bma_pkg::StOk;
      res  <= '0;
    end else begin
      if (cmd.set_stat) stat <= cmd.stat_code;
      if (cmd.set_res)
        res <= bma_pkg::AddrW'(bma_pkg::AddrW'(unit) << eff_blog) + bma_pkg::AddrW'(eff_hdr);
    end
  end

  always_comb begin
    sts.cfg_wr        = cfg_wr;
    sts.clr_last      = &clr_cnt;
    sts.is_free       = (op_cmd == bma_pkg::CmdFree);
    sts.bad_len       = (op_len == '0) || (bma_pkg::PoolW'(op_len) > pool);
    sts.no_fit        = ~|fits;
    sts.bad_addr      = (op_addr < bma_pkg::AddrW'(eff_hdr)) ||
                        ((start & blk_mask) != '0) ||
                        ((start >> eff_blog) >=
                         (bma_pkg::AddrW'(1) << (eff_levels - bma_pkg::EffLvlW'(1))));
    sts.scan_hit      = |cand;
    sts.more_words    = word != lo_last[bma_pkg::NodeW-1:bma_pkg::WordLog2];
    sts.lvl_below_top = (bma_pkg::LvlCmpW'(cur_lvl) + bma_pkg::LvlCmpW'(1)) <
                        bma_pkg::LvlCmpW'(eff_levels);
    sts.can_split     = cur_lvl > lvl;
    sts.am_mark       = am_q[bma_pkg::LvlW];
    sts.buddy_free    = bf_q[node[bma_pkg::WordLog2-1:0] ^ bma_pkg::WordLog2'(1)];
  end

endmodule

// ===== rtl/bma_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences the pool clear, the allocate search and split, and the free and
// merge walk over the datapath.
// ----------------------------------------------------------------------------
module bma_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_busy,
  output logic          out_load,
  input  bma_pkg::sts_t sts,
  output bma_pkg::cmd_t cmd
);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CHECK  = 5'd2;
  localparam logic [4:0] S_SRD    = 5'd3;
  localparam logic [4:0] S_SCHK   = 5'd4;
  localparam logic [4:0] S_CUT_RD = 5'd5;
  localparam logic [4:0] S_CUT_WR = 5'd6;
  localparam logic [4:0] S_SPL_RD = 5'd7;
  localparam logic [4:0] S_SPL_WR = 5'd8;
  localparam logic [4:0] S_AFIN   = 5'd9;
  localparam logic [4:0] S_FRD    = 5'd10;
  localparam logic [4:0] S_FCHK   = 5'd11;
  localparam logic [4:0] S_MTEST  = 5'd12;
  localparam logic [4:0] S_MCHK   = 5'd13;
  localparam logic [4:0] S_TOP_WR = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_free) begin
          if (sts.bad_len) begin
            cmd.set_stat  = 1'b1;
            cmd.stat_code = bma_pkg::StBadLen;
            state_next    = S_DONE;
          end else if (sts.no_fit) begin
            cmd.set_stat  = 1'b1;
            cmd.stat_code = bma_pkg::StNoMem;
            state_next    = S_DONE;
          end else begin
            cmd.pick_level = 1'b1;
            state_next     = S_SRD;
          end
        end else if (sts.bad_addr) begin
          cmd.set_stat  = 1'b1;
          cmd.stat_code = bma_pkg::StBadAddr;
          state_next    = S_DONE;
        end else begin
          cmd.unit_calc = 1'b1;
          state_next    = S_FRD;
        end
      end
      S_SRD: begin
        cmd.scan_rd = 1'b1;
        cmd.bf_rd   = 1'b1;
        state_next  = S_SCHK;
      end
      S_SCHK: begin
        if (sts.scan_hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_CUT_RD;
        end else if (sts.more_words) begin
          cmd.scan_next_word = 1'b1;
          state_next         = S_SRD;
        end else if (sts.lvl_below_top) begin
          cmd.scan_next_level = 1'b1;
          state_next          = S_SRD;
        end else begin
          cmd.set_stat  = 1'b1;
          cmd.stat_code = bma_pkg::StNoMem;
          state_next    = S_DONE;
        end
      end
      S_CUT_RD: begin
        cmd.bf_rd  = 1'b1;
        state_next = S_CUT_WR;
      end
      S_CUT_WR: begin
        // take the found block off the free map
        cmd.bf_wr  = 1'b1;
        cmd.wr_val = 1'b0;
        if (sts.can_split) begin
          cmd.desc      = 1'b1;
          cmd.desc_keep = 1'b1;
          state_next    = S_SPL_RD;
        end else begin
          state_next = S_AFIN;
        end
      end
      S_SPL_RD: begin
        cmd.bf_rd  = 1'b1;
        state_next = S_SPL_WR;
      end
      S_SPL_WR: begin
        // free the upper half at this level
        cmd.bf_wr  = 1'b1;
        cmd.wr_val = 1'b1;
        if (sts.can_split) begin
          cmd.desc   = 1'b1;
          state_next = S_SPL_RD;
        end else begin
          state_next = S_AFIN;
        end
      end
      S_AFIN: begin
        cmd.am_wr   = 1'b1;
        cmd.am_mark = 1'b1;
        cmd.set_res = 1'b1;
        state_next  = S_DONE;
      end
      S_FRD: begin
        cmd.am_rd  = 1'b1;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        if (!sts.am_mark) begin
          cmd.set_stat  = 1'b1;
          cmd.stat_code = bma_pkg::StBadAddr;
          state_next    = S_DONE;
        end else begin
          cmd.am_wr     = 1'b1;
          cmd.load_free = 1'b1;
          state_next    = S_MTEST;
        end
      end
      S_MTEST: begin
        cmd.bf_rd = 1'b1;
        if (sts.lvl_below_top) begin
          cmd.sel_buddy = 1'b1;
          state_next    = S_MCHK;
        end else begin
          state_next = S_TOP_WR;
        end
      end
      S_MCHK: begin
        cmd.bf_wr = 1'b1;
        if (sts.buddy_free) begin
          // absorb the buddy and climb
          cmd.sel_buddy = 1'b1;
          cmd.wr_val    = 1'b0;
          cmd.merge_up  = 1'b1;
          state_next    = S_MTEST;
        end else begin
          cmd.wr_val = 1'b1;
          state_next = S_DONE;
        end
      end
      S_TOP_WR: begin
        cmd.bf_wr  = 1'b1;
        cmd.wr_val = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    // a register write restarts the pool
    if (sts.cfg_wr) state_next = S_CLEAR;
  end

endmodule

// ===== rtl/buddy_memory_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Buddy memory allocator
// Power-of-two buddy allocator with a stream request port, a stream result
// port and a register write port.
// ----------------------------------------------------------------------------
// One request at a time. An allocate scans the bitmap word by word (32 tree
// nodes per word, lowest address first, smallest fitting level upward), then
// splits the found block down one level at a time; a free merges buddies one
// level at a time. Each bitmap update reads a word and then writes it back.
// After reset and after every register write the pool is cleared, during
// which no request is taken. A result waits in an output register while the
// next request is accepted.
// ----------------------------------------------------------------------------
module buddy_memory_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [55:0]                   s_axis_tdata,  // length[25:0], address[51:26]
  input  logic                          s_axis_tuser,  // command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // address_res[25:0]
  output logic [bma_pkg::StatW-1:0]     m_axis_tuser,  // status
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bma_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bma_pkg::CfgDataW-1:0]  cfg_data
);

  bma_pkg::cmd_t                 cmd;
  bma_pkg::sts_t                 sts;
  logic [bma_pkg::StatW-1:0]     stat;
  logic [bma_pkg::AddrW-1:0]     res;
  logic                          out_busy;
  logic                          out_load;
  logic [bma_pkg::AddrW-1:0]     out_addr;

  assign cfg_ready = 1'b1;
  assign out_busy  = m_axis_tvalid && !m_axis_tready;

  bma_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_command (s_axis_tuser),
    .in_length  (s_axis_tdata[25:0]),
    .in_address (s_axis_tdata[51:26]),
    .cmd        (cmd),
    .sts        (sts),
    .stat       (stat),
    .res        (res)
  );

  bma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_busy (out_busy),
    .out_load (out_load),
    .sts      (sts),
    .cmd      (cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= stat;
      out_addr     <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_addr};

endmodule
